[hw/rtl/rpof_pkg.sv]
package rpof_pkg;

    localparam int MAX_LEN_DEF = 256;

    localparam int BASE_W  = 3;
    localparam int RATE_W  = 16;
    localparam int MINOV_W = 9;
    localparam int OUT_W   = 9;

    // configuration register indexes
    localparam logic CFG_RATE  = 1'b0;
    localparam logic CFG_MINOV = 1'b1;

    // which read a base belongs to
    localparam logic READ_ONE = 1'b0;
    localparam logic READ_TWO = 1'b1;

    localparam logic [RATE_W-1:0]  RATE_RST  = 16'd6554;
    localparam logic [MINOV_W-1:0] MINOV_RST = 9'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CMP,
        ST_DRAIN,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // read 1 base against the complement of read 2 base; any non-ACGT is a miss
    function automatic logic base_miss(input logic [BASE_W-1:0] a,
                                       input logic [BASE_W-1:0] b);
        logic mis;
        mis = a[2] | b[2] | (a[1:0] != ~b[1:0]);
        return mis;
    endfunction

endpackage

[hw/rtl/rpof_store.sv]
module rpof_store #(
    parameter int DEPTH = rpof_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [rpof_pkg::BASE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [rpof_pkg::BASE_W-1:0] o_rdata
);

    logic [rpof_pkg::BASE_W-1:0] r_mem [DEPTH];
    logic [rpof_pkg::BASE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/read_pair_overlap_finder_unit.sv]
// Overlap finder for the two reads of a paired-end fragment.
// Input stream: one base per item. tuser selects the read (0 = read 1,
// 1 = read 2), tlast marks the final base of that read, tdata[2:0] is the
// base code (A C G T, anything else is N); bases load back to back while idle.
// The final base of read 2 starts a search over overlap lengths from
// min(len1, len2) down to min_overlap; the input is not ready meanwhile.
// One compare unit reads both base stores once per cycle; a tried length L
// is read out in the compare state, then passes the drain and check states
// before the next shorter length is tried or the search ends.
// Output stream: exactly one item per search, with found, overlap length and
// mismatch count. It sits in an output register, so loading of the next pair
// goes on while it waits; a second search result waits in the block until
// the receiver takes the first one.
// Configuration: write port, index 0 = mismatch rate (Q0.16), index 1 =
// min overlap. Write only while no search is running.
// Reset: rate 6554, min overlap 10, both reads empty, no output item. The
// base stores are not cleared; only loaded positions are ever read.
module read_pair_overlap_finder_unit #(
    parameter int MAX_LEN = rpof_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] base, [7:3] zero
    input  logic        s_axis_tuser,   // [0] read select: 0 = read 1, 1 = read 2
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] found, [9:1] overlap_length,
                                        // [18:10] mismatch_count, [23:19] zero

    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > rpof_pkg::MINOV_W) ? LW : rpof_pkg::MINOV_W;
    localparam int BW = rpof_pkg::BASE_W;
    localparam int OW = rpof_pkg::OUT_W;

    rpof_pkg::t_state r_state, n_state;

    logic [rpof_pkg::RATE_W-1:0]  r_rate;
    logic [rpof_pkg::MINOV_W-1:0] r_minov;

    logic [LW-1:0] r_len1, n_len1, r_len2, n_len2;
    logic          r_rst1, n_rst1, r_rst2, n_rst2;
    logic [LW-1:0] r_span, n_span, r_left, n_left;
    logic [AW-1:0] r_a1, n_a1, r_a2, n_a2;
    logic [LW-1:0] r_miss, n_miss;
    logic [LW-1:0] r_limit;
    logic          r_cmp_vld;
    logic          r_res_found, n_res_found;
    logic [OW-1:0] r_res_len, n_res_len, r_res_miss, n_res_miss;
    logic          r_out_vld, n_out_vld;
    logic          r_out_found, n_out_found;
    logic [OW-1:0] r_out_len, n_out_len, r_out_miss, n_out_miss;

    logic          w_acc;
    logic [BW-1:0] w_base;
    logic [LW-1:0] w_eff1, w_eff2;
    logic          w_we1, w_we2;
    logic          w_rd_en;
    logic [BW-1:0] w_rd1, w_rd2;
    logic [LW-1:0] w_top;
    logic [rpof_pkg::MINOV_W-1:0] w_low;
    logic [LW+15:0] w_prod;
    logic [LW-1:0] w_span_dec;

    assign w_acc  = s_axis_tvalid & s_axis_tready;
    assign w_base = s_axis_tdata[BW-1:0];
    assign w_eff1 = r_rst1 ? '0 : r_len1;
    assign w_eff2 = r_rst2 ? '0 : r_len2;
    assign w_we1  = w_acc & (s_axis_tuser == rpof_pkg::READ_ONE) & (w_eff1 < LW'(MAX_LEN));
    assign w_we2  = w_acc & (s_axis_tuser == rpof_pkg::READ_TWO) & (w_eff2 < LW'(MAX_LEN));
    assign w_rd_en = (r_state == rpof_pkg::ST_CMP);

    assign w_top  = (r_len1 < r_len2) ? r_len1 : r_len2;
    assign w_low  = (r_minov == '0) ? rpof_pkg::MINOV_W'(1) : r_minov;
    assign w_prod = (LW+16)'(r_span) * (LW+16)'(r_rate);
    assign w_span_dec = r_span - 1'b1;

    rpof_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_eff1[AW-1:0]),
        .i_wdata (w_base),
        .i_re    (w_rd_en),
        .i_raddr (r_a1),
        .o_rdata (w_rd1)
    );

    rpof_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store2 (
        .i_clk   (i_clk),
        .i_we    (w_we2),
        .i_waddr (w_eff2[AW-1:0]),
        .i_wdata (w_base),
        .i_re    (w_rd_en),
        .i_raddr (r_a2),
        .o_rdata (w_rd2)
    );

    always_comb begin
        n_state     = r_state;
        n_len1      = r_len1;
        n_len2      = r_len2;
        n_rst1      = r_rst1;
        n_rst2      = r_rst2;
        n_span      = r_span;
        n_left      = r_left;
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_miss      = r_miss;
        n_res_found = r_res_found;
        n_res_len   = r_res_len;
        n_res_miss  = r_res_miss;
        n_out_vld   = r_out_vld & ~m_axis_tready;
        n_out_found = r_out_found;
        n_out_len   = r_out_len;
        n_out_miss  = r_out_miss;

        // compare result lands in the cycle after its read
        if (r_cmp_vld && rpof_pkg::base_miss(w_rd1, w_rd2)) begin
            n_miss = r_miss + 1'b1;
        end

        unique case (r_state)
            rpof_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (s_axis_tuser == rpof_pkg::READ_ONE) begin
                        n_len1 = w_we1 ? LW'(w_eff1 + 1'b1) : w_eff1;
                        n_rst1 = s_axis_tlast;
                    end else begin
                        n_len2 = w_we2 ? LW'(w_eff2 + 1'b1) : w_eff2;
                        n_rst2 = s_axis_tlast;
                        if (s_axis_tlast) begin
                            n_state = rpof_pkg::ST_SETUP;
                        end
                    end
                end
            end
            rpof_pkg::ST_SETUP: begin
                if (CW'(w_top) < CW'(w_low)) begin
                    n_res_found = 1'b0;
                    n_res_len   = '0;
                    n_res_miss  = '0;
                    n_state     = rpof_pkg::ST_FINISH;
                end else begin
                    n_span  = w_top;
                    n_left  = w_top;
                    n_a1    = AW'(r_len1 - w_top);
                    n_a2    = AW'(r_len2 - 1'b1);
                    n_miss  = '0;
                    n_state = rpof_pkg::ST_CMP;
                end
            end
            rpof_pkg::ST_CMP: begin
                n_a1   = r_a1 + 1'b1;
                n_a2   = r_a2 - 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == LW'(1)) begin
                    n_state = rpof_pkg::ST_DRAIN;
                end
            end
            rpof_pkg::ST_DRAIN: begin
                n_state = rpof_pkg::ST_CHECK;
            end
            rpof_pkg::ST_CHECK: begin
                if (r_miss <= r_limit) begin
                    n_res_found = 1'b1;
                    n_res_len   = OW'(r_span);
                    n_res_miss  = OW'(r_miss);
                    n_state     = rpof_pkg::ST_FINISH;
                end else if (CW'(r_span) <= CW'(w_low)) begin
                    n_res_found = 1'b0;
                    n_res_len   = '0;
                    n_res_miss  = '0;
                    n_state     = rpof_pkg::ST_FINISH;
                end else begin
                    n_span  = w_span_dec;
                    n_left  = w_span_dec;
                    n_a1    = AW'(r_len1 - w_span_dec);
                    n_a2    = AW'(r_len2 - 1'b1);
                    n_miss  = '0;
                    n_state = rpof_pkg::ST_CMP;
                end
            end
            rpof_pkg::ST_FINISH: begin
                // wait for the output register to be free
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_res_found;
                    n_out_len   = r_res_len;
                    n_out_miss  = r_res_miss;
                    n_state     = rpof_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpof_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpof_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= rpof_pkg::RATE_RST;
            r_minov   <= rpof_pkg::MINOV_RST;
            r_len1    <= '0;
            r_len2    <= '0;
            r_rst1    <= 1'b1;
            r_rst2    <= 1'b1;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rpof_pkg::CFG_RATE:  r_rate  <= i_cfg_wdata;
                    rpof_pkg::CFG_MINOV: r_minov <= i_cfg_wdata[rpof_pkg::MINOV_W-1:0];
                    default: ;
                endcase
            end
            r_len1    <= n_len1;
            r_len2    <= n_len2;
            r_rst1    <= n_rst1;
            r_rst2    <= n_rst2;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_span      <= n_span;
        r_left      <= n_left;
        r_a1        <= n_a1;
        r_a2        <= n_a2;
        r_miss      <= n_miss;
        r_limit     <= w_prod[LW+15:16];
        r_res_found <= n_res_found;
        r_res_len   <= n_res_len;
        r_res_miss  <= n_res_miss;
        r_out_found <= n_out_found;
        r_out_len   <= n_out_len;
        r_out_miss  <= n_out_miss;
    end

    assign s_axis_tready = (r_state == rpof_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out_miss, r_out_len, r_out_found};

endmodule
